FILE: hw/rtl/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared types and constants of the stroke point interpolator: widths of the
// coordinate, root and remainder datapaths, register indexes and opcodes.
// ----------------------------------------------------------------------------
package spi_pkg;

  localparam int CAPACITY   = 32;
  localparam int COORD_BITS = 12;

  localparam int REL_BITS  = COORD_BITS + 1;
  localparam int REG_W     = 13;
  localparam int CFG_IDX_W = 1;

  // squared move, radicand in Q16, root in Q8
  localparam int SQ_W  = 2 * REL_BITS;
  localparam int RAD_W = SQ_W + 16;
  localparam int DQ_W  = RAD_W / 2;

  // step index, per-axis quotient and remainder
  localparam int I_W   = DQ_W - 7;
  localparam int Q_W   = COORD_BITS + 2;
  localparam int REM_W = DQ_W + 2;

  localparam int HELD_W = $clog2(CAPACITY + 2);
  localparam int CMP_W  = (REG_W > COORD_BITS) ? REG_W : COORD_BITS;

  localparam logic [REG_W-1:0] SCREEN_WIDTH_RST  = REG_W'(640);
  localparam logic [REG_W-1:0] SCREEN_HEIGHT_RST = REG_W'(480);

  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = CFG_IDX_W'(1);

  localparam logic OP_MOTION = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  localparam logic [RAD_W-1:0] ROOT_TOP = RAD_W'(1) << (RAD_W - 2);
  localparam logic [RAD_W-1:0] ROOT_ONE = RAD_W'(1);

  localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_SQX   = 7'b0000010,
    S_SQY   = 7'b0000100,
    S_ROOT  = 7'b0001000,
    S_EVENT = 7'b0010000,
    S_STEP  = 7'b0100000,
    S_OUT   = 7'b1000000
  } spi_state_t;

  // floor quotient and remainder of one axis along the path
  typedef struct packed {
    logic signed [Q_W-1:0]   q;
    logic signed [REM_W-1:0] rem;
  } spi_axis_t;

endpackage

FILE: hw/rtl/stroke_point_interpolator.sv
// ----------------------------------------------------------------------------
// stroke_point_interpolator
// Turns pen-down motion beats into stroke points along the path back to the
// previous pen position, limited by the held-point capacity.
// ----------------------------------------------------------------------------
// A motion beat on the screen gives the event point first and then one point
// per whole pixel of path length toward pos - rel; a flush beat clears the
// held-point count and gives no output, an off-screen beat is dropped. The
// block takes one input beat at a time. The path length comes from one
// shared multiplier (one axis after the other) and a bit-pair square root
// unit, after which the event point is registered for output; each further
// point then takes one step of the per-axis quotient/remainder walk plus
// the output beat, which waits while the output is stalled.
module stroke_point_interpolator (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_opcode,
  input  logic [spi_pkg::COORD_BITS-1:0]         in_pos_x,
  input  logic [spi_pkg::COORD_BITS-1:0]         in_pos_y,
  input  logic signed [spi_pkg::REL_BITS-1:0]    in_rel_x,
  input  logic signed [spi_pkg::REL_BITS-1:0]    in_rel_y,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [spi_pkg::COORD_BITS-1:0]         out_point_x,
  output logic [spi_pkg::COORD_BITS-1:0]         out_point_y,
  output logic                                   out_overflowed,
  output logic                                   out_last,
  input  logic                                   cfg_we,
  input  logic [spi_pkg::CFG_IDX_W-1:0]          cfg_index,
  input  logic [spi_pkg::REG_W-1:0]              cfg_wdata
);

  localparam logic signed [spi_pkg::Q_W-1:0] Q_ONE = spi_pkg::Q_W'(1);
  localparam int CAPACITY_M1 = spi_pkg::CAPACITY - 1;

  spi_pkg::spi_state_t state_r, state_nxt;

  logic [spi_pkg::REG_W-1:0] scr_w_r, scr_h_r;
  logic [spi_pkg::HELD_W-1:0] held_r, held_nxt;
  logic out_valid_r, out_valid_nxt;

  logic [spi_pkg::COORD_BITS-1:0] px_r, px_nxt, py_r, py_nxt;
  logic signed [spi_pkg::REL_BITS-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [spi_pkg::SQ_W-1:0] sq_r, sq_nxt;
  logic [spi_pkg::RAD_W-1:0] rad_r, rad_nxt, root_r, root_nxt, bit_r, bit_nxt;
  logic [spi_pkg::I_W-1:0] idx_r, idx_nxt;
  spi_pkg::spi_axis_t ax_r, ax_nxt, ay_r, ay_nxt;

  logic [spi_pkg::COORD_BITS-1:0] pt_x_r, pt_x_nxt, pt_y_r, pt_y_nxt;
  logic ovf_r, ovf_nxt, last_r, last_nxt;

  logic signed [spi_pkg::REL_BITS-1:0] mul_op;
  logic signed [spi_pkg::SQ_W-1:0] mul_prod;
  logic [spi_pkg::RAD_W-1:0] root_sum;
  logic [spi_pkg::DQ_W-1:0] dq;
  logic [spi_pkg::HELD_W-1:0] held_inc;
  logic [spi_pkg::I_W-1:0] idx_inc;
  logic on_screen, more;
  logic signed [spi_pkg::REM_W-1:0] step_x, step_y;
  spi_pkg::spi_axis_t ax_step, ay_step;

  function automatic spi_pkg::spi_axis_t step_axis(
    input spi_pkg::spi_axis_t a,
    input logic signed [spi_pkg::REM_W-1:0] stp,
    input logic [spi_pkg::DQ_W-1:0] d
  );
    logic signed [spi_pkg::REM_W-1:0] diff;
    logic signed [spi_pkg::REM_W-1:0] ds;
    spi_pkg::spi_axis_t o;
    ds   = signed'(spi_pkg::REM_W'(d));
    diff = a.rem - stp;
    o    = a;
    if (diff < 0) begin
      o.rem = diff + ds;
      o.q   = a.q - Q_ONE;
    end else if (diff >= ds) begin
      o.rem = diff - ds;
      o.q   = a.q + Q_ONE;
    end else begin
      o.rem = diff;
    end
    return o;
  endfunction

  function automatic logic [spi_pkg::COORD_BITS-1:0] sat_coord(
    input logic signed [spi_pkg::Q_W-1:0] q
  );
    logic [spi_pkg::COORD_BITS-1:0] res;
    if (q[spi_pkg::Q_W-1]) begin
      res = '0;
    end else if (q[spi_pkg::Q_W-2:spi_pkg::COORD_BITS] != '0) begin
      res = spi_pkg::COORD_MAX;
    end else begin
      res = q[spi_pkg::COORD_BITS-1:0];
    end
    return res;
  endfunction

  // shared squaring multiplier: x move then y move
  assign mul_op   = (state_r == spi_pkg::S_SQX) ? rx_r : ry_r;
  assign mul_prod = mul_op * mul_op;

  assign root_sum = root_r + bit_r;
  assign dq       = root_r[spi_pkg::DQ_W-1:0];
  assign held_inc = held_r + spi_pkg::HELD_W'(1);
  assign idx_inc  = idx_r + spi_pkg::I_W'(1);

  assign on_screen = (spi_pkg::CMP_W'(in_pos_x) < spi_pkg::CMP_W'(scr_w_r)) &&
                     (spi_pkg::CMP_W'(in_pos_y) < spi_pkg::CMP_W'(scr_h_r));

  // move of rel * 256 per step, taken off the remainder
  assign step_x  = spi_pkg::REM_W'(signed'({rx_r, 8'h00}));
  assign step_y  = spi_pkg::REM_W'(signed'({ry_r, 8'h00}));
  assign ax_step = step_axis(ax_r, step_x, dq);
  assign ay_step = step_axis(ay_r, step_y, dq);

  always_comb begin
    state_nxt     = state_r;
    held_nxt      = held_r;
    out_valid_nxt = out_valid_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    rx_nxt        = rx_r;
    ry_nxt        = ry_r;
    sq_nxt        = sq_r;
    rad_nxt       = rad_r;
    root_nxt      = root_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    ax_nxt        = ax_r;
    ay_nxt        = ay_r;
    pt_x_nxt      = pt_x_r;
    pt_y_nxt      = pt_y_r;
    ovf_nxt       = ovf_r;
    last_nxt      = last_r;
    more          = 1'b0;
    unique case (state_r)
      spi_pkg::S_IDLE: begin
        if (in_valid) begin
          if (in_opcode == spi_pkg::OP_FLUSH) begin
            held_nxt = '0;
          end else if (on_screen) begin
            px_nxt    = in_pos_x;
            py_nxt    = in_pos_y;
            rx_nxt    = in_rel_x;
            ry_nxt    = in_rel_y;
            state_nxt = spi_pkg::S_SQX;
          end
        end
      end
      spi_pkg::S_SQX: begin
        sq_nxt    = unsigned'(mul_prod);
        state_nxt = spi_pkg::S_SQY;
      end
      spi_pkg::S_SQY: begin
        rad_nxt   = {sq_r + unsigned'(mul_prod), 16'h0000};
        root_nxt  = '0;
        bit_nxt   = spi_pkg::ROOT_TOP;
        state_nxt = spi_pkg::S_ROOT;
      end
      spi_pkg::S_ROOT: begin
        if (rad_r >= root_sum) begin
          rad_nxt  = rad_r - root_sum;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r == spi_pkg::ROOT_ONE) begin
          state_nxt = spi_pkg::S_EVENT;
        end
      end
      spi_pkg::S_EVENT: begin
        more          = ({spi_pkg::I_W'(1), 8'h00} < {1'b0, dq}) &&
                        (held_inc < spi_pkg::HELD_W'(CAPACITY_M1));
        pt_x_nxt      = px_r;
        pt_y_nxt      = py_r;
        ax_nxt.q      = signed'(spi_pkg::Q_W'(px_r));
        ax_nxt.rem    = '0;
        ay_nxt.q      = signed'(spi_pkg::Q_W'(py_r));
        ay_nxt.rem    = '0;
        idx_nxt       = spi_pkg::I_W'(1);
        last_nxt      = !more;
        ovf_nxt       = !more && (held_inc > spi_pkg::HELD_W'(spi_pkg::CAPACITY));
        held_nxt      = ovf_nxt ? '0 : held_inc;
        out_valid_nxt = 1'b1;
        state_nxt     = spi_pkg::S_OUT;
      end
      spi_pkg::S_STEP: begin
        more          = ({idx_inc, 8'h00} < {1'b0, dq}) &&
                        (held_inc < spi_pkg::HELD_W'(CAPACITY_M1));
        ax_nxt        = ax_step;
        ay_nxt        = ay_step;
        pt_x_nxt      = sat_coord(ax_step.q);
        pt_y_nxt      = sat_coord(ay_step.q);
        idx_nxt       = idx_inc;
        last_nxt      = !more;
        ovf_nxt       = !more && (held_inc > spi_pkg::HELD_W'(spi_pkg::CAPACITY));
        held_nxt      = ovf_nxt ? '0 : held_inc;
        out_valid_nxt = 1'b1;
        state_nxt     = spi_pkg::S_OUT;
      end
      spi_pkg::S_OUT: begin
        if (!out_stall) begin
          out_valid_nxt = 1'b0;
          state_nxt     = last_r ? spi_pkg::S_IDLE : spi_pkg::S_STEP;
        end
      end
      default: begin
        state_nxt = spi_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spi_pkg::S_IDLE;
      held_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= spi_pkg::SCREEN_WIDTH_RST;
      scr_h_r <= spi_pkg::SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        spi_pkg::REG_SCREEN_WIDTH:  scr_w_r <= cfg_wdata;
        spi_pkg::REG_SCREEN_HEIGHT: scr_h_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    px_r   <= px_nxt;
    py_r   <= py_nxt;
    rx_r   <= rx_nxt;
    ry_r   <= ry_nxt;
    sq_r   <= sq_nxt;
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    idx_r  <= idx_nxt;
    ax_r   <= ax_nxt;
    ay_r   <= ay_nxt;
    pt_x_r <= pt_x_nxt;
    pt_y_r <= pt_y_nxt;
    ovf_r  <= ovf_nxt;
    last_r <= last_nxt;
  end

  assign in_stall       = (state_r != spi_pkg::S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_point_x    = pt_x_r;
  assign out_point_y    = pt_y_r;
  assign out_overflowed = ovf_r;
  assign out_last       = last_r;

  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= spi_pkg::HELD_W'(spi_pkg::CAPACITY))
    else $error("held count above capacity");

  a_valid_in_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (state_r == spi_pkg::S_OUT))
    else $error("output beat outside output state");

  a_ovf_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ovf_r) |-> last_r)
    else $error("overflow flag on a non-final point");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && last_r) |=> !in_stall)
    else $error("not ready after final point");

endmodule

FILE: bench/tb_stroke_point_interpolator.sv
// ----------------------------------------------------------------------------
// tb_stroke_point_interpolator
// Self-checking bench: drives motion and flush beats through several screen
// sizes, predicts every stroke point in a behavioral model of the path walk
// and compares the output beats in order, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_stroke_point_interpolator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 60;
  localparam int HOLD_CYCLES = 400;

  typedef struct {
    logic                                op;
    logic [spi_pkg::COORD_BITS-1:0]      px;
    logic [spi_pkg::COORD_BITS-1:0]      py;
    logic signed [spi_pkg::REL_BITS-1:0] rx;
    logic signed [spi_pkg::REL_BITS-1:0] ry;
  } motion_t;

  typedef struct {
    logic [spi_pkg::COORD_BITS-1:0] x;
    logic [spi_pkg::COORD_BITS-1:0] y;
    logic                           ovf;
    logic                           last;
  } point_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                                in_valid = 1'b0;
  logic                                in_stall;
  logic                                in_opcode = spi_pkg::OP_MOTION;
  logic [spi_pkg::COORD_BITS-1:0]      in_pos_x = '0;
  logic [spi_pkg::COORD_BITS-1:0]      in_pos_y = '0;
  logic signed [spi_pkg::REL_BITS-1:0] in_rel_x = '0;
  logic signed [spi_pkg::REL_BITS-1:0] in_rel_y = '0;
  logic                                out_valid;
  logic                                out_stall = 1'b0;
  logic [spi_pkg::COORD_BITS-1:0]      out_point_x;
  logic [spi_pkg::COORD_BITS-1:0]      out_point_y;
  logic                                out_overflowed;
  logic                                out_last;
  logic                                cfg_we = 1'b0;
  logic [spi_pkg::CFG_IDX_W-1:0]       cfg_index = spi_pkg::REG_SCREEN_WIDTH;
  logic [spi_pkg::REG_W-1:0]           cfg_wdata = '0;

  stroke_point_interpolator dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_rel_x      (in_rel_x),
    .in_rel_y      (in_rel_y),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_overflowed(out_overflowed),
    .out_last      (out_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // bench copy of block state
  logic [spi_pkg::REG_W-1:0] scr_w = spi_pkg::SCREEN_WIDTH_RST;
  logic [spi_pkg::REG_W-1:0] scr_h = spi_pkg::SCREEN_HEIGHT_RST;
  int                        held = 0;

  motion_t beats_todo[$];
  point_t  pts_due[$];
  motion_t on_wire;

  int queued = 0;
  int taken = 0;
  int pts_checked = 0;
  int ovf_seen = 0;
  int bad_cnt = 0;
  int cyc = 0;
  int pen_x = 0;
  int pen_y = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit want_hold = 1'b0;
  bit steady = 1'b0;

  task automatic flag_mismatch(string what, int got, int want);
    bad_cnt++;
    if (bad_cnt <= 40) begin
      $display("[%0t] mismatch %s: got %0d, expected %0d (point %0d)",
               $realtime, what, got, want, pts_checked);
    end
  endtask

  function automatic longint root_floor(longint v);
    longint r;
    longint t;
    r = 0;
    for (int b = 21; b >= 0; b--) begin
      t = r | (longint'(1) << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  function automatic logic [spi_pkg::COORD_BITS-1:0] clip_coord(longint v);
    if (v < 0) return '0;
    if (v > longint'(spi_pkg::COORD_MAX)) return spi_pkg::COORD_MAX;
    return v[spi_pkg::COORD_BITS-1:0];
  endfunction

  // expected stroke points of one accepted beat
  function automatic void trace_stroke(motion_t m);
    longint px;
    longint py;
    longint rx;
    longint ry;
    longint dq;
    longint i;
    point_t p;
    if (m.op == spi_pkg::OP_FLUSH) begin
      held = 0;
      return;
    end
    if ({1'b0, m.px} >= scr_w || {1'b0, m.py} >= scr_h) return;
    px = m.px;
    py = m.py;
    rx = m.rx;
    ry = m.ry;
    dq = root_floor((rx * rx + ry * ry) << 16);
    p.x = m.px;
    p.y = m.py;
    p.ovf = 1'b0;
    p.last = 1'b0;
    held++;
    // walk back toward pos - rel, one point per whole pixel of length
    for (i = 1; (i << 8) < dq && held < spi_pkg::CAPACITY - 1; i++) begin
      pts_due.push_back(p);
      p.x = clip_coord((px * dq - rx * (i << 8)) / dq);
      p.y = clip_coord((py * dq - ry * (i << 8)) / dq);
      held++;
    end
    if (held > spi_pkg::CAPACITY) begin
      held = 0;
      p.ovf = 1'b1;
    end
    p.last = 1'b1;
    pts_due.push_back(p);
  endfunction

  function automatic motion_t mk(logic op, int px, int py, int rx, int ry);
    motion_t m;
    m.op = op;
    m.px = px[spi_pkg::COORD_BITS-1:0];
    m.py = py[spi_pkg::COORD_BITS-1:0];
    m.rx = rx[spi_pkg::REL_BITS-1:0];
    m.ry = ry[spi_pkg::REL_BITS-1:0];
    return m;
  endfunction

  function automatic int clamp(int v, int hi);
    if (v < 0) return 0;
    if (v > hi) return hi;
    return v;
  endfunction

  // mostly pen strokes that follow on from the previous point, some noise
  function automatic motion_t next_motion();
    motion_t m;
    int lim_x;
    int lim_y;
    int span;
    int nx;
    int ny;
    int r;
    lim_x = (scr_w == 0) ? 1 : ((scr_w > 4096) ? 4096 : int'(scr_w));
    lim_y = (scr_h == 0) ? 1 : ((scr_h > 4096) ? 4096 : int'(scr_h));
    r = $urandom_range(0, 99);
    m = mk(spi_pkg::OP_MOTION, $urandom, $urandom, $urandom, $urandom);
    if (r < 7) begin
      m.op = spi_pkg::OP_FLUSH;
    end else if (r < 75) begin
      span = ($urandom_range(0, 3) == 0) ? 400 : (($urandom_range(0, 1) == 0) ? 3 : 30);
      nx = clamp(pen_x + int'($urandom_range(0, 2 * span)) - span, lim_x - 1);
      ny = clamp(pen_y + int'($urandom_range(0, 2 * span)) - span, lim_y - 1);
      m = mk(spi_pkg::OP_MOTION, nx, ny, nx - pen_x, ny - pen_y);
      pen_x = nx;
      pen_y = ny;
    end else if (r < 88) begin
      m.px = spi_pkg::COORD_BITS'($urandom_range(0, lim_x - 1));
      m.py = spi_pkg::COORD_BITS'($urandom_range(0, lim_y - 1));
    end
    return m;
  endfunction

  task automatic post(motion_t m);
    beats_todo.push_back(m);
    queued++;
  endtask

  task automatic post_random(int n);
    @(negedge clk);
    pen_x = 0;
    pen_y = 0;
    repeat (n) post(next_motion());
  endtask

  // flush and off-screen beats give no output, so let the block settle too
  task automatic drain();
    do @(negedge clk); while (taken != queued || pts_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [spi_pkg::CFG_IDX_W-1:0] idx, int val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[spi_pkg::REG_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == spi_pkg::REG_SCREEN_WIDTH) scr_w = val[spi_pkg::REG_W-1:0];
    else scr_h = val[spi_pkg::REG_W-1:0];
    @(posedge clk);
  endtask

  // input driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (in_valid && in_stall) begin
      in_valid <= 1'b1;
    end else begin
      if (in_valid) begin
        trace_stroke(on_wire);
        taken <= taken + 1;
      end
      if (beats_todo.size() != 0 && (steady || $urandom_range(0, 99) >= 27)) begin
        on_wire = beats_todo.pop_front();
        in_valid <= 1'b1;
        in_opcode <= on_wire.op;
        in_pos_x <= on_wire.px;
        in_pos_y <= on_wire.py;
        in_rel_x <= on_wire.rx;
        in_rel_y <= on_wire.ry;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall, with one long hold-off to back the block up
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_done) begin
      out_stall <= 1'b1;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 27);
    end
  end

  // output monitor
  always @(posedge clk) begin
    point_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pts_due.size() == 0) begin
        flag_mismatch("unexpected point x", int'(out_point_x), -1);
      end else begin
        want = pts_due.pop_front();
        if (out_point_x !== want.x) flag_mismatch("point_x", int'(out_point_x), int'(want.x));
        if (out_point_y !== want.y) flag_mismatch("point_y", int'(out_point_y), int'(want.y));
        if (out_overflowed !== want.ovf) begin
          flag_mismatch("overflowed", int'(out_overflowed), int'(want.ovf));
        end
        if (out_last !== want.last) flag_mismatch("last", int'(out_last), int'(want.last));
      end
      pts_checked <= pts_checked + 1;
      if (out_overflowed === 1'b1) ovf_seen <= ovf_seen + 1;
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cyc);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset screen 640x480: sub-pixel moves, exact lengths, screen edges
    @(negedge clk);
    post(mk(spi_pkg::OP_MOTION, 100, 100, 0, 0));
    post(mk(spi_pkg::OP_MOTION, 100, 100, 1, 0));
    post(mk(spi_pkg::OP_MOTION, 101, 101, 1, 1));
    post(mk(spi_pkg::OP_MOTION, 200, 150, 10, -7));
    post(mk(spi_pkg::OP_MOTION, 639, 479, 3, 4));
    post(mk(spi_pkg::OP_MOTION, 640, 10, 2, 2));
    post(mk(spi_pkg::OP_MOTION, 10, 480, 2, 2));
    post(mk(spi_pkg::OP_FLUSH, 4095, 4095, -1, -1));
    post(mk(spi_pkg::OP_MOTION, 0, 0, 5, 5));
    post(mk(spi_pkg::OP_MOTION, 5, 0, -4095, -4096));
    drain();

    write_reg(spi_pkg::REG_SCREEN_WIDTH, 4096);
    write_reg(spi_pkg::REG_SCREEN_HEIGHT, 4096);
    // coordinate extremes, saturation at both ends, capacity overflow
    @(negedge clk);
    post(mk(spi_pkg::OP_FLUSH, 0, 0, 0, 0));
    post(mk(spi_pkg::OP_MOTION, 4095, 4095, -20, -20));
    post(mk(spi_pkg::OP_MOTION, 4095, 0, 4095, -4095));
    post(mk(spi_pkg::OP_MOTION, 0, 4095, -4096, 4095));
    post(mk(spi_pkg::OP_MOTION, 2048, 2048, -4096, -4096));
    post(mk(spi_pkg::OP_MOTION, 4095, 4095, 4095, 4095));
    post(mk(spi_pkg::OP_MOTION, 1234, 3000, 0, -1));
    post(mk(spi_pkg::OP_MOTION, 300, 300, 0, 0));
    post(mk(spi_pkg::OP_MOTION, 300, 300, 0, 0));
    post(mk(spi_pkg::OP_MOTION, 4095, 4095, 0, 4095));
    post(mk(spi_pkg::OP_MOTION, 0, 0, 4095, 0));
    drain();

    write_reg(spi_pkg::REG_SCREEN_WIDTH, 1);
    write_reg(spi_pkg::REG_SCREEN_HEIGHT, 1);
    post_random(12);
    drain();

    write_reg(spi_pkg::REG_SCREEN_WIDTH, 0);
    write_reg(spi_pkg::REG_SCREEN_HEIGHT, 4096);
    post_random(6);
    drain();

    write_reg(spi_pkg::REG_SCREEN_WIDTH, 8191);
    write_reg(spi_pkg::REG_SCREEN_HEIGHT, 8191);
    post_random(40);
    drain();

    // no idling here, and the receiver backs off for a long stretch
    write_reg(spi_pkg::REG_SCREEN_WIDTH, 4096);
    write_reg(spi_pkg::REG_SCREEN_HEIGHT, 4096);
    post_random(120);
    steady = 1'b1;
    want_hold = 1'b1;
    drain();
    steady = 1'b0;

    repeat (2) begin
      write_reg(spi_pkg::REG_SCREEN_WIDTH, $urandom_range(1, 4096));
      write_reg(spi_pkg::REG_SCREEN_HEIGHT, $urandom_range(1, 4096));
      post_random(70);
      drain();
    end

    repeat (40) @(posedge clk);
    if (pts_due.size() != 0) flag_mismatch("points never delivered", 0, pts_due.size());
    $display("%0d input beats over 8 screen settings, %0d stroke points checked",
             taken, pts_checked);
    $display("%0d overflow marks seen, one long output hold-off", ovf_seen);
    if (bad_cnt == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: stroke_point_interpolator.f
hw/rtl/spi_pkg.sv
hw/rtl/stroke_point_interpolator.sv
bench/tb_stroke_point_interpolator.sv
